// File: rtl/core/pps_pkg.sv
// Shared types, codes and helpers for the preemptive priority scheduler.
package pps_pkg;

  // Default table depth
  localparam int MAX_PROCESSES_DEF = 16;

  // Field widths
  localparam int TIME_W   = 21;
  localparam int ARR_W    = 16;
  localparam int BURST_W  = 16;
  localparam int PRI_W    = 8;
  localparam int PID_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_LOADED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RAN      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [ARR_W-1:0]   arrival_time;
    logic [BURST_W-1:0] burst_length;
    logic [PRI_W-1:0]   priority_level;
  } pps_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    process_id;
    logic                finished;
    logic [TIME_W-1:0]   completion_time;
    logic [TIME_W-1:0]   turnaround_time;
    logic [TIME_W-1:0]   waiting_time;
    logic                all_done;
  } pps_out_t;

  // One process table row
  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [PRI_W-1:0]   prio;
  } pps_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_RESULT
  } pps_state_t;

  // Subtraction that clamps at zero
  function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

// File: rtl/core/pps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/preemptive_priority_scheduler.sv
// Top level of the tick-driven preemptive priority scheduler.
//
// Usage: requests enter on in_valid/in_ready/in_data. A load request
// (opcode 0) adds a process to the table; a tick request (opcode 1)
// runs the most urgent arrived, unfinished process for one time unit.
// Every request yields exactly one result on out_valid/out_ready/out_data.
// A load that finds room writes its row on acceptance; its result goes
// through the RESULT state into the output register, and the block takes
// its next request once RESULT hands the result on. A tick passes through
// SCAN, UPDATE and RESULT, because the process table is scanned through
// the single read port of its RAM, one row per cycle; with an empty
// table the scan is skipped and the tick goes from idle to UPDATE.
// One request is in flight at a time; in_ready is high in the idle state.
// The output register parts the two sides: a new request is accepted
// while a result still waits, and the block holds its next result until
// the receiver takes the pending one.
// Reset clears the load and completion counts, the time counter and all
// handshake state. Table rows are only read after their load writes them.
module preemptive_priority_scheduler #(
  parameter int MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pps_pkg::pps_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pps_pkg::pps_out_t out_data
);

  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int ENT_W = $bits(pps_pkg::pps_entry_t);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PROCESSES);
  localparam int BURST_W_LOC = pps_pkg::BURST_W;

  // Control state
  pps_pkg::pps_state_t state_r, state_nxt;
  logic [CNT_W-1:0] loaded_cnt_r, loaded_cnt_nxt;
  logic [CNT_W-1:0] done_cnt_r, done_cnt_nxt;
  logic [pps_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic cmp_valid_r, cmp_valid_nxt;
  logic found_r, found_nxt;
  logic out_valid_r, out_valid_nxt;

  // Payload state
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  pps_pkg::pps_entry_t best_r, best_nxt;
  logic [pps_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [pps_pkg::PID_W-1:0] res_pid_r, res_pid_nxt;
  logic res_fin_r, res_fin_nxt;
  logic [pps_pkg::TIME_W-1:0] res_ct_r, res_ct_nxt;
  logic [pps_pkg::TIME_W-1:0] res_tat_r, res_tat_nxt;
  pps_pkg::pps_out_t out_data_r, out_data_nxt;

  // RAM ports
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  pps_pkg::pps_entry_t ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;

  // Helpers
  logic                        in_fire;
  logic                        out_free;
  logic                        full;
  logic                        scan_last;
  logic                        cand_elig;
  logic                        cand_better;
  pps_pkg::pps_entry_t         cand;
  logic [pps_pkg::TIME_W-1:0]  time_inc;
  logic [BURST_W_LOC-1:0]      rem_dec;
  logic [31:0]                 load_pid;
  logic [31:0]                 sel_pid;
  logic [pps_pkg::BURST_W-1:0] load_burst;

  pps_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_PROCESSES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == pps_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign full      = (loaded_cnt_r >= FULL_CNT);
  assign scan_last = cmp_valid_r && (cmp_idx_r == loaded_cnt_r - 1'b1);

  // Candidate compare against the running best
  assign cand        = pps_pkg::pps_entry_t'(ram_rdata);
  assign cand_elig   = (pps_pkg::TIME_W'(cand.arrival) <= time_r) && (cand.remaining != '0);
  assign cand_better = !found_r || (cand.prio < best_r.prio) ||
                       ((cand.prio == best_r.prio) && (cand.arrival < best_r.arrival));

  // Update arithmetic
  assign time_inc   = (time_r != pps_pkg::TIME_MAX) ? (time_r + 1'b1) : time_r;
  assign rem_dec    = best_r.remaining - 1'b1;
  assign load_pid   = 32'(loaded_cnt_r) + 32'd1;
  assign sel_pid    = 32'(best_idx_r) + 32'd1;
  assign load_burst = (in_data.burst_length == '0) ? BURST_W_LOC'(1) : in_data.burst_length;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pps_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_data.opcode == pps_pkg::OP_LOAD) begin
            state_nxt = pps_pkg::S_RESULT;
          end else if (loaded_cnt_r == '0) begin
            state_nxt = pps_pkg::S_UPDATE;
          end else begin
            state_nxt = pps_pkg::S_SCAN;
          end
        end
      end
      pps_pkg::S_SCAN: begin
        if (scan_last) begin
          state_nxt = pps_pkg::S_UPDATE;
        end
      end
      pps_pkg::S_UPDATE: begin
        state_nxt = pps_pkg::S_RESULT;
      end
      pps_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = pps_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pps_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    loaded_cnt_nxt = loaded_cnt_r;
    done_cnt_nxt   = done_cnt_r;
    time_nxt       = time_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_valid_nxt  = 1'b0;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    res_status_nxt = res_status_r;
    res_pid_nxt    = res_pid_r;
    res_fin_nxt    = res_fin_r;
    res_ct_nxt     = res_ct_r;
    res_tat_nxt    = res_tat_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ram_we         = 1'b0;
    ram_waddr      = loaded_cnt_r[IDX_W-1:0];
    ram_wdata      = '0;
    ram_raddr      = rd_idx_r[IDX_W-1:0];

    case (state_r)
      pps_pkg::S_IDLE: begin
        rd_idx_nxt = '0;
        found_nxt  = 1'b0;
        if (in_fire && (in_data.opcode == pps_pkg::OP_LOAD)) begin
          res_fin_nxt = 1'b0;
          res_ct_nxt  = '0;
          res_tat_nxt = '0;
          if (full) begin
            res_status_nxt = pps_pkg::ST_REJECTED;
            res_pid_nxt    = '0;
          end else begin
            ram_we              = 1'b1;
            ram_wdata.arrival   = in_data.arrival_time;
            ram_wdata.burst     = load_burst;
            ram_wdata.remaining = load_burst;
            ram_wdata.prio      = in_data.priority_level;
            loaded_cnt_nxt      = loaded_cnt_r + 1'b1;
            res_status_nxt      = pps_pkg::ST_LOADED;
            res_pid_nxt         = load_pid[pps_pkg::PID_W-1:0];
          end
        end
      end
      pps_pkg::S_SCAN: begin
        // Issue one row read per cycle, compare the row read last cycle
        if (rd_idx_r < loaded_cnt_r) begin
          rd_idx_nxt    = rd_idx_r + 1'b1;
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = rd_idx_r;
        end
        if (cmp_valid_r && cand_elig && cand_better) begin
          found_nxt    = 1'b1;
          best_idx_nxt = cmp_idx_r[IDX_W-1:0];
          best_nxt     = cand;
        end
      end
      pps_pkg::S_UPDATE: begin
        time_nxt    = time_inc;
        res_fin_nxt = 1'b0;
        res_ct_nxt  = '0;
        res_tat_nxt = '0;
        if (found_r) begin
          // Run the chosen process for one unit and write it back
          ram_we              = 1'b1;
          ram_waddr           = best_idx_r;
          ram_wdata           = best_r;
          ram_wdata.remaining = rem_dec;
          res_status_nxt      = pps_pkg::ST_RAN;
          res_pid_nxt         = sel_pid[pps_pkg::PID_W-1:0];
          if (rem_dec == '0) begin
            done_cnt_nxt = done_cnt_r + 1'b1;
            res_fin_nxt  = 1'b1;
            res_ct_nxt   = time_inc;
            res_tat_nxt  = pps_pkg::sat_sub(time_inc, pps_pkg::TIME_W'(best_r.arrival));
          end
        end else begin
          res_status_nxt = pps_pkg::ST_IDLE;
          res_pid_nxt    = '0;
        end
      end
      pps_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.status          = res_status_r;
          out_data_nxt.process_id      = res_pid_r;
          out_data_nxt.finished        = res_fin_r;
          out_data_nxt.completion_time = res_ct_r;
          out_data_nxt.turnaround_time = res_tat_r;
          out_data_nxt.waiting_time    = res_fin_r ?
              pps_pkg::sat_sub(res_tat_r, pps_pkg::TIME_W'(best_r.burst)) : '0;
          out_data_nxt.all_done        = (done_cnt_r == loaded_cnt_r);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pps_pkg::S_IDLE;
      loaded_cnt_r <= '0;
      done_cnt_r   <= '0;
      time_r       <= '0;
      rd_idx_r     <= '0;
      cmp_idx_r    <= '0;
      cmp_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      loaded_cnt_r <= loaded_cnt_nxt;
      done_cnt_r   <= done_cnt_nxt;
      time_r       <= time_nxt;
      rd_idx_r     <= rd_idx_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
    res_status_r <= res_status_nxt;
    res_pid_r    <= res_pid_nxt;
    res_fin_r    <= res_fin_nxt;
    res_ct_r     <= res_ct_nxt;
    res_tat_r    <= res_tat_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Completions never outnumber loads
  a_done_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    done_cnt_r <= loaded_cnt_r)
    else $error("completed count exceeds loaded count");

  // Table never grows past its depth
  a_loaded_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_cnt_r <= FULL_CNT)
    else $error("loaded count exceeds table depth");

  // A selected process always has work left
  a_best_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pps_pkg::S_UPDATE && found_r) |-> (best_r.remaining != '0))
    else $error("selected process has no remaining work");

  // Compare pipeline only runs during the scan
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_valid_r |-> (state_r == pps_pkg::S_SCAN))
    else $error("compare stage active outside scan");

  // A finish is only reported on a run result
  a_fin_on_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.finished) |-> (out_data_r.status == pps_pkg::ST_RAN))
    else $error("finished flag on a non-run result");

endmodule

// File: sim/preemptive_priority_scheduler_test.sv
// Self-checking testbench for the preemptive priority scheduler: directed and random requests.
`timescale 1ns / 100ps

module preemptive_priority_scheduler_test;

  // Process table tracker: mirrors the scheduler state, predicts each
  // request's report and checks what the block returns against it.
  class process_table;
    pps_pkg::pps_entry_t      rows [pps_pkg::MAX_PROCESSES_DEF];
    int unsigned              loaded;
    int unsigned              completed;
    bit [pps_pkg::TIME_W-1:0] now;
    pps_pkg::pps_out_t        due_reports [$];
    int unsigned              reports_matched;
    int unsigned              report_errors;

    // Apply one accepted request to the table and queue the report it causes
    function void accept_request(input pps_pkg::pps_in_t req);
      pps_pkg::pps_out_t         rep;
      int                        pick;
      int unsigned               i;
      bit [pps_pkg::BURST_W-1:0] len;
      rep = '0;
      if (req.opcode == pps_pkg::OP_LOAD) begin
        if (loaded >= pps_pkg::MAX_PROCESSES_DEF) begin
          rep.status = pps_pkg::ST_REJECTED;
        end else begin
          // a zero burst still needs one unit of service
          len = (req.burst_length == '0) ? pps_pkg::BURST_W'(1) : req.burst_length;
          rows[loaded].arrival   = req.arrival_time;
          rows[loaded].burst     = len;
          rows[loaded].remaining = len;
          rows[loaded].prio      = req.priority_level;
          loaded++;
          rep.status     = pps_pkg::ST_LOADED;
          rep.process_id = pps_pkg::PID_W'(loaded);
        end
      end else begin
        // most urgent arrived row; ties by arrival, then lowest index
        pick = -1;
        for (i = 0; i < loaded; i++) begin
          if (rows[i].arrival <= now && rows[i].remaining != '0) begin
            if (pick < 0 || rows[i].prio < rows[pick].prio ||
                (rows[i].prio == rows[pick].prio &&
                 rows[i].arrival < rows[pick].arrival)) begin
              pick = i;
            end
          end
        end
        if (now != pps_pkg::TIME_MAX) now++;
        if (pick < 0) begin
          rep.status = pps_pkg::ST_IDLE;
        end else begin
          rep.status     = pps_pkg::ST_RAN;
          rep.process_id = pps_pkg::PID_W'(pick + 1);
          rows[pick].remaining--;
          if (rows[pick].remaining == '0) begin
            completed++;
            rep.finished        = 1'b1;
            rep.completion_time = now;
            // times clamp at zero instead of wrapping
            if (now > rows[pick].arrival) rep.turnaround_time = now - rows[pick].arrival;
            if (rep.turnaround_time > rows[pick].burst) begin
              rep.waiting_time = rep.turnaround_time - rows[pick].burst;
            end
          end
        end
      end
      rep.all_done = (completed == loaded);
      due_reports.push_back(rep);
    endfunction

    // Compare one returned report with the oldest one still due
    function void match_report(input pps_pkg::pps_out_t got);
      pps_pkg::pps_out_t want;
      bit                bad;
      if (due_reports.size() == 0) begin
        report_errors++;
        if (report_errors <= 10) begin
          $display("unrequested report: st=%0d id=%0d fin=%0d", got.status,
                   got.process_id, got.finished);
        end
        return;
      end
      want = due_reports.pop_front();
      bad  = (got.status !== want.status) || (got.process_id !== want.process_id) ||
             (got.finished !== want.finished) ||
             (got.completion_time !== want.completion_time) ||
             (got.turnaround_time !== want.turnaround_time) ||
             (got.waiting_time !== want.waiting_time) || (got.all_done !== want.all_done);
      if (bad) begin
        report_errors++;
        if (report_errors <= 10) begin
          $display("report mismatch: want st=%0d id=%0d fin=%0d ct=%0d tat=%0d wt=%0d done=%0d",
                   want.status, want.process_id, want.finished, want.completion_time,
                   want.turnaround_time, want.waiting_time, want.all_done);
          $display("                 got  st=%0d id=%0d fin=%0d ct=%0d tat=%0d wt=%0d done=%0d",
                   got.status, got.process_id, got.finished, got.completion_time,
                   got.turnaround_time, got.waiting_time, got.all_done);
        end
      end else begin
        reports_matched++;
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  pps_pkg::pps_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pps_pkg::pps_out_t out_data;

  process_table ptab = new;

  preemptive_priority_scheduler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Tick request; the load-only fields carry random noise
  function automatic pps_pkg::pps_in_t tick_req();
    pps_pkg::pps_in_t r;
    r.opcode         = pps_pkg::OP_TICK;
    r.arrival_time   = pps_pkg::ARR_W'($urandom);
    r.burst_length   = pps_pkg::BURST_W'($urandom);
    r.priority_level = pps_pkg::PRI_W'($urandom);
    return r;
  endfunction

  function automatic pps_pkg::pps_in_t load_req(input int unsigned arr,
                                                input int unsigned len,
                                                input int unsigned pri);
    pps_pkg::pps_in_t r;
    r.opcode         = pps_pkg::OP_LOAD;
    r.arrival_time   = pps_pkg::ARR_W'(arr);
    r.burst_length   = pps_pkg::BURST_W'(len);
    r.priority_level = pps_pkg::PRI_W'(pri);
    return r;
  endfunction

  // Mostly ticks; loads arrive near the current time with short bursts
  function automatic pps_pkg::pps_in_t random_req();
    pps_pkg::pps_in_t r;
    int               arr;
    r = tick_req();
    if ($urandom_range(0, 9) < ((ptab.loaded < pps_pkg::MAX_PROCESSES_DEF) ? 1 : 2)) begin
      r.opcode = pps_pkg::OP_LOAD;
      if (ptab.loaded == pps_pkg::MAX_PROCESSES_DEF - 1) begin
        // last free row: every field at its top value, never gets to run
        r.arrival_time   = '1;
        r.burst_length   = '1;
        r.priority_level = '1;
      end else if (ptab.loaded < pps_pkg::MAX_PROCESSES_DEF) begin
        arr = int'(ptab.now) + int'($urandom_range(0, 35)) - 10;
        r.arrival_time = (arr < 0) ? '0 : pps_pkg::ARR_W'(arr);
        r.burst_length = pps_pkg::BURST_W'($urandom_range(0, 10));
        r.priority_level = ($urandom_range(0, 5) == 0) ? pps_pkg::PRI_W'($urandom)
                                                       : pps_pkg::PRI_W'($urandom_range(0, 7));
      end
    end
    return r;
  endfunction

  // Offer one request after a random gap and wait for its handshake
  task automatic offer(input pps_pkg::pps_in_t req, input bit calm);
    int unsigned gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ptab.accept_request(req);
  endtask

  // Request side: reset, directed cases, random traffic, drain
  initial begin
    int unsigned n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer(tick_req(), 1'b0);           // tick before any load: idle, all done
    offer(load_req(0, 0, 0), 1'b0);    // zero burst is served as one unit
    offer(tick_req(), 1'b0);           // runs and finishes at once
    offer(tick_req(), 1'b0);           // idle after everything finished
    offer(load_req(5, 3, 4), 1'b0);    // arrives later
    offer(tick_req(), 1'b0);           // idle with work still pending
    offer(load_req(2, 4, 4), 1'b0);    // same priority, earlier arrival
    offer(load_req(2, 2, 4), 1'b0);    // full tie: lower index wins
    offer(tick_req(), 1'b0);
    offer(tick_req(), 1'b0);
    offer(load_req(6, 2, 1), 1'b0);    // more urgent arrival preempts
    repeat (7) offer(tick_req(), 1'b0);
    offer(load_req(0, 1, 255), 1'b0);  // least urgent, waits for everyone
    repeat (6) offer(tick_req(), 1'b0);

    for (n = 0; n < 380; n++) begin
      offer(random_req(), n >= 150 && n < 200);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (ptab.due_reports.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (ptab.report_errors == 0 && ptab.due_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Report side: random stalls, one long hold-off to back the block up
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && ptab.reports_matched >= 100) begin
        held = 1'b1;
        gap  = 300;
      end else begin
        gap = pick_gap(ptab.reports_matched >= 250 && ptab.reports_matched < 300);
      end
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
  end

  // Take each accepted report
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ptab.match_report(out_data);
  end

  // Hang guard
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
